// ===== sv/length_prefixed_frame_receiver_top_assert.svh =====
// Assertion macros used by the frame receiver checker.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPFR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lpfr_pkg.sv =====
package lpfr_pkg;

	typedef logic [7:0] byte_t;

	// One result of the frame receiver.
	typedef struct packed {
		byte_t frame_byte;
		byte_t byte_index;
		logic  last_of_frame;
		logic  checksum_good;
		byte_t message_type;
	} res_t;

	localparam byte_t TYPE_INDEX = 8'd1;

endpackage

// ===== sv/length_prefixed_frame_receiver_top.sv =====
// Length-prefixed frame receiver: takes one link byte per request and sustains one byte
// per clock cycle while the output is not stalled; each request passes an input register,
// then the result register. The frame state (length, byte counter, running modulo-256 sum
// and type byte) is updated as a byte leaves the input register. Zero bytes between
// frames are dropped without a result; every frame byte gives one result with its index,
// and the last byte also carries the end flag, the checksum check and, in frames of two
// or more bytes, the type byte. No clearing pass is needed after reset.
module length_prefixed_frame_receiver_top
	import lpfr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  byte_t rx_byte,
	output logic  out_valid,
	input  logic  out_stall,
	output byte_t frame_byte,
	output byte_t byte_index,
	output logic  last_of_frame,
	output logic  checksum_good,
	output byte_t message_type
);

	logic  valid_s1;
	byte_t byte_s1;
	logic  has_result;
	logic  can_load;
	logic  advance;
	res_t  core_res;
	res_t  out_res;

	// Filler bytes leave the input register even while the output is stalled.
	assign advance  = valid_s1 && (!has_result || can_load);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	lpfr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (byte_s1),
		.advance    (advance),
		.has_result (has_result),
		.res        (core_res)
	);

	lpfr_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (advance && has_result),
		.load_res   (core_res),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res)
	);

	assign frame_byte    = out_res.frame_byte;
	assign byte_index    = out_res.byte_index;
	assign last_of_frame = out_res.last_of_frame;
	assign checksum_good = out_res.checksum_good;
	assign message_type  = out_res.message_type;

endmodule

// ===== sv/lpfr_core.sv =====
module lpfr_core
	import lpfr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  byte_t rx_byte,
	input  logic  advance,
	output logic  has_result,
	output res_t  res
);

	logic  in_frame_q;
	byte_t len_q;
	byte_t seen_q;
	byte_t sum_q;
	byte_t type_q;

	byte_t eff_len;
	byte_t eff_seen;
	byte_t eff_sum;
	byte_t eff_type;
	byte_t type_nx;
	logic  last;

	// A byte taken while idle opens a frame, so the state is seen as freshly cleared.
	always_comb begin
		eff_len  = in_frame_q ? len_q : rx_byte;
		eff_seen = in_frame_q ? seen_q : '0;
		eff_sum  = in_frame_q ? sum_q : '0;
		eff_type = in_frame_q ? type_q : '0;
		type_nx  = (eff_seen == TYPE_INDEX) ? rx_byte : eff_type;
		last     = ({1'b0, eff_seen} + 9'd1) == {1'b0, eff_len};
		has_result = in_frame_q || (rx_byte != '0);

		res.frame_byte    = rx_byte;
		res.byte_index    = eff_seen;
		res.last_of_frame = last;
		res.checksum_good = last && (eff_sum == rx_byte);
		res.message_type  = (last && (eff_len >= 8'd2)) ? type_nx : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			len_q      <= '0;
			seen_q     <= '0;
			sum_q      <= '0;
			type_q     <= '0;
		end else if (advance && has_result) begin
			len_q  <= eff_len;
			type_q <= type_nx;
			if (last) begin
				in_frame_q <= 1'b0;
				seen_q     <= '0;
				sum_q      <= '0;
			end else begin
				in_frame_q <= 1'b1;
				seen_q     <= eff_seen + 8'd1;
				sum_q      <= eff_sum + rx_byte;
			end
		end
	end

endmodule

// ===== sv/lpfr_out_reg.sv =====
module lpfr_out_reg
	import lpfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load_valid,
	input  res_t load_res,
	output logic can_load,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

// ===== sv/lpfr_checker.sv =====
`include "length_prefixed_frame_receiver_top_assert.svh"

module lpfr_checker
	import lpfr_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_stall,
	input byte_t rx_byte,
	input logic  out_valid,
	input logic  out_stall,
	input byte_t frame_byte,
	input byte_t byte_index,
	input logic  last_of_frame,
	input logic  checksum_good,
	input byte_t message_type
);

	logic [25:0] out_word;
	logic        status_clear;
	logic        out_last;

	assign out_word     = {frame_byte, byte_index, last_of_frame, checksum_good, message_type};
	assign status_clear = !checksum_good && (message_type == 8'd0);
	assign out_last     = out_valid && last_of_frame;

	// A stalled request must stay in place.
	`LPFR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(rx_byte), "request changed")

	// A stalled result must stay in place.
	`LPFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result changed")

	// A frame never starts with a zero length byte.
	`LPFR_ASSERT_SAME(a_len_nonzero, out_valid && (byte_index == 8'd0), frame_byte != 8'd0, "zero length")

	// Only the last byte carries the checksum flag and the type byte.
	`LPFR_ASSERT_SAME(a_not_last_clear, out_valid && !last_of_frame, status_clear, "status set early")

	// In a two-byte frame the type byte is the checksum byte itself.
	`LPFR_ASSERT_SAME(a_short_type, out_last && (byte_index == 8'd1), message_type == frame_byte, "bad type")

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (.*);
